// ===== hdl/packet_application_classifier_macros.svh =====
// Assertion helpers shared by the classifier modules
`ifndef PACKET_APPLICATION_CLASSIFIER_MACROS_SVH
`define PACKET_APPLICATION_CLASSIFIER_MACROS_SVH
// Check that a condition implies a consequence on the same edge
`define PAC_ASSERT_IMPL(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// Check that a condition implies a consequence on the following edge
`define PAC_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

// ===== hdl/pac_pkg.sv =====
package pac_pkg;
    localparam int MAX_PAYLOAD_DEF = 512;
    localparam int PREFIX_LEN = 20;
    localparam int WINDOW_LEN = 7;

    typedef struct packed {
        logic [2:0]  kind_flags;
        logic [7:0]  l4_proto;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic        dns_ok;
        logic [7:0]  data_byte;
        logic        has_byte;
        logic        last_of_packet;
    } t_in_item;

    typedef struct packed {
        logic [4:0] application;
        logic [1:0] confidence;
    } t_out_item;

    // Front-to-back request: header, prefix-derived flags and markers
    typedef struct packed {
        logic [2:0]  kind_flags;
        logic [7:0]  l4_proto;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic        dns_ok;
        logic        sig_bt;
        logic        n12_d;
        logic        sig_http;
        logic        sig_tls;
        logic        sig_quic;
        logic        sig_ssh;
        logic        sig_mqtt_hdr;
        logic [4:0]  markers;
    } t_req;

    localparam logic [4:0] APP_UNKNOWN = 5'd0, APP_TCP = 5'd1, APP_UDP = 5'd2,
        APP_ARP = 5'd3, APP_ICMP = 5'd4, APP_ICMP6 = 5'd5, APP_EAPOL = 5'd6,
        APP_WIFI = 5'd7, APP_DNS = 5'd8, APP_MDNS = 5'd9, APP_DHCP = 5'd10,
        APP_HTTP = 5'd11, APP_TLS = 5'd12, APP_QUIC = 5'd13, APP_SSDP = 5'd14,
        APP_NTP = 5'd15, APP_SSH = 5'd16, APP_FTP = 5'd17, APP_TELNET = 5'd18,
        APP_SMB = 5'd19, APP_MQTT = 5'd20, APP_BT = 5'd21, APP_DHT = 5'd22,
        APP_LLMNR = 5'd23, APP_NBNS = 5'd24, APP_SMTP = 5'd25, APP_IMAP = 5'd26,
        APP_POP3 = 5'd27;
    localparam logic [1:0] CONF_TRANSPORT = 2'd0, CONF_PORT = 2'd1, CONF_CONFIRMED = 2'd2;
    localparam logic [7:0] PROTO_ICMP = 8'd1, PROTO_TCP = 8'd6, PROTO_UDP = 8'd17,
        PROTO_ICMP6 = 8'd58;
endpackage

// ===== hdl/packet_application_classifier.sv =====
// After a packet's last item is accepted, its request is held in the queue, then
// the rule decoder writes the result into the output register.
// Throughput: one item per cycle while the request queue is not full.
// Reset: synchronous active-low; clears byte count, markers, queue and output valid.
module packet_application_classifier import pac_pkg::*; #(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);
    // Front/back request link through a two-entry queue
    t_req f_req, q_req;
    logic f_valid, q_full, q_valid, q_pop;

    // Track bytes and signatures; push one request per packet end
    pac_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_item,
        .o_req_valid(f_valid), .i_req_full(q_full), .o_req(f_req)
    );

    // Hold pending requests so each side may stall on its own
    pac_queue u_queue (
        .i_clk, .i_rst_n, .i_push(f_valid), .i_data(f_req), .o_full(q_full),
        .o_valid(q_valid), .i_pop(q_pop), .o_data(q_req)
    );

    // Decode the rule priority and register the result
    pac_back u_back (
        .i_clk, .i_rst_n, .i_req_valid(q_valid), .i_req(q_req), .o_pop(q_pop),
        .o_valid, .i_stall, .o_item
    );
endmodule

// ===== hdl/pac_front.sv =====
module pac_front import pac_pkg::*; #(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    localparam int CW = $clog2(MAX_PAYLOAD + 1)
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_item,
    output logic     o_req_valid,
    input  logic     i_req_full,
    output t_req     o_req
);
    logic [CW-1:0] r_count, n_count;
    logic [7:0]    r_pre [PREFIX_LEN];
    logic [7:0]    r_win [WINDOW_LEN];
    logic [4:0]    r_mark, n_mark;
    logic          take, acc, last;
    logic [7:0]    b;
    logic [7:0]    p [PREFIX_LEN];
    logic [CW-1:0] n;
    logic [4:0]    hit;

    localparam logic [7:0] BT [19] = '{"B","i","t","T","o","r","r","e","n","t"," ",
        "p","r","o","t","o","c","o","l"};

    assign o_stall = i_req_full;
    assign acc  = i_valid && !i_req_full;
    assign b    = i_item.data_byte;
    assign last = i_item.last_of_packet;
    assign take = acc && i_item.has_byte && (r_count < CW'(MAX_PAYLOAD));

    function automatic logic pfx(input logic [7:0] a [PREFIX_LEN], input logic [CW-1:0] cnt,
                                 input logic [63:0] s, input int len);
        logic ok;
        ok = (cnt >= CW'(len));
        for (int i = 0; i < 8; i++)
            if (i < len && a[i] != s[63-8*i -: 8]) ok = 1'b0;
        return ok;
    endfunction

    always_comb begin
        hit = '0;
        hit[0] = r_count >= CW'(5) && r_win[0] == ":" && r_win[1] == "1" && r_win[2] == "y"
              && r_win[3] == ":" && r_win[4] == "1" && (b == "q" || b == "r");
        hit[1] = r_count >= CW'(5) && b == "T" && r_win[0] == "T" && r_win[1] == "Q"
              && r_win[2] == "M" && r_win[3] == 8'h04 && r_win[4] == 8'h00;
        hit[2] = r_count >= CW'(7) && b == "p" && r_win[0] == "d" && r_win[1] == "s"
              && r_win[2] == "I" && r_win[3] == "Q" && r_win[4] == "M"
              && r_win[5] == 8'h06 && r_win[6] == 8'h00;
        hit[3] = r_count >= CW'(3) && b == "B" && r_win[0] == "M" && r_win[1] == "S"
              && r_win[2] == 8'hFF;
        hit[4] = r_count >= CW'(3) && b == "B" && r_win[0] == "M" && r_win[1] == "S"
              && r_win[2] == 8'hFE;
        for (int i = 0; i < PREFIX_LEN; i++)
            p[i] = (take && r_count == CW'(i)) ? b : r_pre[i];
        n = r_count + CW'(take);
        n_mark = r_mark | (take ? hit : 5'd0);
        n_count = n;
        if (acc && last) begin
            n_count = '0;
            n_mark  = '0;
        end else if (!acc) begin
            n_count = r_count;
            n_mark  = r_mark;
        end
    end

    always_comb begin
        logic bt;
        bt = (n >= CW'(20)) && p[0] == 8'd19;
        for (int i = 0; i < 19; i++) if (p[i+1] != BT[i]) bt = 1'b0;
        o_req.kind_flags = i_item.kind_flags;
        o_req.l4_proto   = i_item.l4_proto;
        o_req.src_port   = i_item.src_port;
        o_req.dst_port   = i_item.dst_port;
        o_req.dns_ok     = i_item.dns_ok;
        o_req.sig_bt   = bt;
        o_req.n12_d    = n >= CW'(12) && p[0] == "d";
        o_req.sig_http = pfx(p, n, "GET     ", 4) || pfx(p, n, "POST    ", 5)
            || pfx(p, n, "PUT     ", 4) || pfx(p, n, "HEAD    ", 5)
            || pfx(p, n, "DELETE  ", 7) || pfx(p, n, "OPTIONS ", 8)
            || pfx(p, n, "PATCH   ", 6) || pfx(p, n, "CONNECT ", 8)
            || pfx(p, n, "HTTP/   ", 5);
        o_req.sig_tls  = n >= CW'(5) && p[0] >= 8'd20 && p[0] <= 8'd23 && p[1] == 8'd3
                      && p[2] <= 8'd4;
        o_req.sig_quic = n >= CW'(6) && p[0][7:6] == 2'b11
                      && (p[1] | p[2] | p[3] | p[4]) != 8'd0;
        o_req.sig_ssh  = pfx(p, n, "SSH-    ", 4);
        o_req.sig_mqtt_hdr = n >= CW'(8) && p[0][7:4] == 4'h1;
        o_req.markers  = r_mark | (take ? hit : 5'd0);
    end

    assign o_req_valid = acc && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_mark  <= '0;
        end else begin
            r_count <= n_count;
            r_mark  <= n_mark;
        end
        if (take) begin
            for (int i = 0; i < PREFIX_LEN; i++)
                if (r_count == CW'(i)) r_pre[i] <= b;
            r_win[0] <= b;
            for (int k = 1; k < WINDOW_LEN; k++) r_win[k] <= r_win[k-1];
        end
    end

    `include "packet_application_classifier_macros.svh"
    `PAC_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, acc && last, r_count == '0 && r_mark == '0)
    `PAC_ASSERT_IMPL(a_sat, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_PAYLOAD))
    `PAC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !acc, r_count == $past(r_count))
endmodule

// ===== hdl/pac_queue.sv =====
module pac_queue import pac_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_data,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_req o_data
);
    t_req       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) r_mem[r_wp] <= i_data;
    end

    `include "packet_application_classifier_macros.svh"
    `PAC_ASSERT_IMPL(a_no_over, i_clk, i_rst_n, i_push, !o_full)
    `PAC_ASSERT_IMPL(a_no_under, i_clk, i_rst_n, i_pop, o_valid)
    `PAC_ASSERT_IMPL(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= 2'd2)
endmodule

// ===== hdl/pac_back.sv =====
module pac_back import pac_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_req_valid,
    input  t_req      i_req,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);
    logic      r_valid;
    t_out_item r_item, c;
    logic      sk_ok;

    function automatic logic pt(input t_req q, input logic [15:0] v);
        return q.src_port == v || q.dst_port == v;
    endfunction

    always_comb begin
        logic udp, hw;
        udp = i_req.l4_proto == PROTO_UDP;
        hw  = (i_req.src_port >= 16'd6881 && i_req.src_port <= 16'd6999)
           || (i_req.dst_port >= 16'd6881 && i_req.dst_port <= 16'd6999);
        c.confidence = CONF_CONFIRMED;
        c.application = APP_UNKNOWN;
        priority if (i_req.kind_flags[0]) c.application = APP_ARP;
        else if (i_req.kind_flags[1]) c.application = APP_EAPOL;
        else if (i_req.kind_flags[2]) c.application = APP_WIFI;
        else if (i_req.l4_proto == PROTO_ICMP) c.application = APP_ICMP;
        else if (i_req.l4_proto == PROTO_ICMP6) c.application = APP_ICMP6;
        else if (i_req.sig_bt) c.application = APP_BT;
        else if (udp && i_req.n12_d && i_req.markers[0]) c.application = APP_DHT;
        else if (i_req.sig_http) c.application = APP_HTTP;
        else if (i_req.sig_tls) c.application = APP_TLS;
        else if (udp && i_req.sig_quic && pt(i_req, 16'd443)) c.application = APP_QUIC;
        else if (i_req.sig_ssh) c.application = APP_SSH;
        else if (i_req.markers[4:3] != 2'd0) c.application = APP_SMB;
        else if (i_req.sig_mqtt_hdr && i_req.markers[2:1] != 2'd0) c.application = APP_MQTT;
        else if (i_req.dns_ok || pt(i_req, 16'd53) || pt(i_req, 16'd5353)) begin
            c.confidence = i_req.dns_ok ? CONF_CONFIRMED : CONF_PORT;
            c.application = pt(i_req, 16'd5353) ? APP_MDNS : APP_DNS;
        end else begin
            c.confidence = CONF_PORT;
            priority if (pt(i_req, 16'd67) || pt(i_req, 16'd68)) c.application = APP_DHCP;
            else if (pt(i_req, 16'd5355)) c.application = APP_LLMNR;
            else if (pt(i_req, 16'd137)) c.application = APP_NBNS;
            else if (pt(i_req, 16'd1900)) c.application = APP_SSDP;
            else if (pt(i_req, 16'd123)) c.application = APP_NTP;
            else if (pt(i_req, 16'd80) || pt(i_req, 16'd8080) || pt(i_req, 16'd8000))
                c.application = APP_HTTP;
            else if (pt(i_req, 16'd443) || pt(i_req, 16'd8443))
                c.application = udp ? APP_QUIC : APP_TLS;
            else if (pt(i_req, 16'd22)) c.application = APP_SSH;
            else if (pt(i_req, 16'd20) || pt(i_req, 16'd21)) c.application = APP_FTP;
            else if (pt(i_req, 16'd23)) c.application = APP_TELNET;
            else if (pt(i_req, 16'd139) || pt(i_req, 16'd445)) c.application = APP_SMB;
            else if (pt(i_req, 16'd1883) || pt(i_req, 16'd8883)) c.application = APP_MQTT;
            else if (hw) c.application = APP_BT;
            else if (pt(i_req, 16'd25) || pt(i_req, 16'd465) || pt(i_req, 16'd587))
                c.application = APP_SMTP;
            else if (pt(i_req, 16'd143) || pt(i_req, 16'd993)) c.application = APP_IMAP;
            else if (pt(i_req, 16'd110) || pt(i_req, 16'd995)) c.application = APP_POP3;
            else begin
                c.confidence = CONF_TRANSPORT;
                c.application = i_req.l4_proto == PROTO_TCP ? APP_TCP
                              : (udp ? APP_UDP : APP_UNKNOWN);
            end
        end
    end

    assign sk_ok   = !r_valid || !i_stall;
    assign o_pop   = i_req_valid && sk_ok;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else if (sk_ok) r_valid <= i_req_valid;
        if (o_pop) r_item <= c;
    end

    `include "packet_application_classifier_macros.svh"
    `PAC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_valid && i_stall, r_valid && $stable(r_item))
    `PAC_ASSERT_NEXT(a_pop_loads, i_clk, i_rst_n, o_pop, r_valid)
    `PAC_ASSERT_NEXT(a_idle_drains, i_clk, i_rst_n, !i_req_valid && !i_stall, !r_valid)
endmodule
